/* sv/fbct_pkg.sv */
// Package with the shared types, codes and constants of the focus and break countdown timer.
`timescale 1ns / 1ps

package fbct_pkg;

    localparam int TIME_W = 32;
    localparam int DUR_W  = 23;
    localparam int MIN_W  = 7;
    localparam int SEC_W  = 6;
    localparam int TOT_W  = 13;

    localparam logic [DUR_W-1:0]  DUR_MAX     = 23'd5999000;
    localparam logic [DUR_W-1:0]  FOCUS_RESET = 23'd1500000;
    localparam logic [DUR_W-1:0]  BREAK_RESET = 23'd300000;
    localparam logic [TIME_W-1:0] HOLD_MS     = 32'd1000;

    // Rounding offset and reciprocals for the divisions by 1000 and by 60.
    localparam logic [23:0] ROUND_UP   = 24'd999;
    localparam logic [23:0] RECIP_1000 = 24'd8589935;
    localparam int          SHIFT_1000 = 33;
    localparam logic [13:0] RECIP_60   = 14'd8739;
    localparam int          SHIFT_60   = 19;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_PAUSE  = 2'd2;
    localparam logic [1:0] MODE_RESET  = 2'd3;

    localparam logic REG_FOCUS = 1'b0;
    localparam logic REG_BREAK = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_ms;
    } evt_t;

    typedef struct packed {
        logic [DUR_W-1:0] remaining_ms;
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic             in_break;
        logic             is_paused;
        logic             holding_zero;
    } res_t;

    typedef struct packed {
        logic [DUR_W-1:0] left_ms;
        logic             in_break;
        logic             is_paused;
        logic             holding_zero;
    } status_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } conv_ctl_t;

endpackage

/* sv/fbct_core.sv */
// Session state, duration registers and the per-event update of the countdown timer.
`timescale 1ns / 1ps

module fbct_core
    import fbct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  evt_t             evt,
    input  logic             step,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [DUR_W-1:0] wr_data,
    output status_t          status
);

    logic [DUR_W-1:0]  focus_reg, focus_next;
    logic [DUR_W-1:0]  break_len_reg, break_len_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] pause_reg, pause_next;
    logic [TIME_W-1:0] end_reg, end_next;
    logic [DUR_W-1:0]  left_reg, left_next;
    logic              brk_reg, brk_next;
    logic              paused_reg, paused_next;
    logic              hold_reg, hold_next;

    logic [DUR_W-1:0]  wr_sat;
    logic [DUR_W-1:0]  dur;
    logic [DUR_W-1:0]  other_dur;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since_end;
    logic [TIME_W-1:0] span;
    logic              expired;

    assign wr_sat    = (wr_data > DUR_MAX) ? DUR_MAX : wr_data;
    assign dur       = brk_reg ? break_len_reg : focus_reg;
    assign other_dur = brk_reg ? focus_reg : break_len_reg;
    assign elapsed   = evt.now_ms - start_reg;
    assign since_end = evt.now_ms - end_reg;
    assign span      = evt.now_ms - pause_reg;
    assign expired   = elapsed >= {{(TIME_W-DUR_W){1'b0}}, dur};

    always_comb
    begin
        focus_next     = focus_reg;
        break_len_next = break_len_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_FOCUS: focus_next = wr_sat;
                REG_BREAK: break_len_next = wr_sat;
                default:   focus_next = focus_reg;
            endcase
        end
    end

    always_comb
    begin
        start_next  = start_reg;
        pause_next  = pause_reg;
        end_next    = end_reg;
        left_next   = left_reg;
        brk_next    = brk_reg;
        paused_next = paused_reg;
        hold_next   = hold_reg;
        unique case (evt.mode)
            MODE_BEGIN:
            begin
                start_next = evt.now_ms;
            end
            MODE_UPDATE:
            begin
                if (!paused_reg)
                begin
                    if (hold_reg)
                    begin
                        if (since_end >= HOLD_MS)
                        begin
                            brk_next   = !brk_reg;
                            start_next = evt.now_ms;
                            left_next  = other_dur;
                            hold_next  = 1'b0;
                        end
                    end
                    else if (expired)
                    begin
                        left_next = '0;
                        end_next  = evt.now_ms;
                        hold_next = 1'b1;
                    end
                    else
                    begin
                        left_next = dur - elapsed[DUR_W-1:0];
                    end
                end
            end
            MODE_PAUSE:
            begin
                if (!paused_reg)
                begin
                    pause_next  = evt.now_ms;
                    paused_next = 1'b1;
                end
                else
                begin
                    start_next = start_reg + span;
                    if (hold_reg)
                    begin
                        end_next = end_reg + span;
                    end
                    paused_next = 1'b0;
                end
            end
            MODE_RESET:
            begin
                start_next = evt.now_ms;
                if (paused_reg)
                begin
                    pause_next = evt.now_ms;
                    left_next  = dur;
                end
                end_next  = '0;
                hold_next = 1'b0;
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    assign status.left_ms      = left_next;
    assign status.in_break     = brk_next;
    assign status.is_paused    = paused_next;
    assign status.holding_zero = hold_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg     <= FOCUS_RESET;
            break_len_reg <= BREAK_RESET;
            start_reg     <= '0;
            pause_reg     <= '0;
            end_reg       <= '0;
            left_reg      <= '0;
            brk_reg       <= 1'b0;
            paused_reg    <= 1'b0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            focus_reg     <= focus_next;
            break_len_reg <= break_len_next;
            if (step)
            begin
                start_reg  <= start_next;
                pause_reg  <= pause_next;
                end_reg    <= end_next;
                left_reg   <= left_next;
                brk_reg    <= brk_next;
                paused_reg <= paused_next;
                hold_reg   <= hold_next;
            end
        end
    end

endmodule

/* sv/fbct_conv.sv */
// Conversion of the remaining time into rounded minutes and seconds over registered stages.
`timescale 1ns / 1ps

module fbct_conv
    import fbct_pkg::*;
(
    input  logic      clk,
    input  conv_ctl_t ctl,
    input  status_t   status,
    output res_t      res
);

    status_t          st1_reg;
    status_t          st2_reg;
    logic [TOT_W-1:0] tot_reg;
    res_t             res_reg;

    logic [23:0]      rounded;
    logic [47:0]      prod_1000;
    logic [TOT_W-1:0] tot_next;
    logic [26:0]      prod_60;
    logic [MIN_W-1:0] min_val;
    logic [TOT_W-1:0] min_x60;
    logic [TOT_W-1:0] sec_full;

    assign rounded   = {1'b0, st1_reg.left_ms} + ROUND_UP;
    assign prod_1000 = rounded * RECIP_1000;
    assign tot_next  = prod_1000[SHIFT_1000 +: TOT_W];

    assign prod_60  = tot_reg * RECIP_60;
    assign min_val  = prod_60[SHIFT_60 +: MIN_W];
    assign min_x60  = {min_val, 6'b0} - {4'b0, min_val, 2'b0};
    assign sec_full = tot_reg - min_x60;

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            st1_reg <= status;
        end
        if (ctl.ld2)
        begin
            st2_reg <= st1_reg;
            tot_reg <= tot_next;
        end
        if (ctl.ld3)
        begin
            res_reg.remaining_ms <= st2_reg.left_ms;
            res_reg.minutes      <= min_val;
            res_reg.seconds      <= sec_full[SEC_W-1:0];
            res_reg.in_break     <= st2_reg.in_break;
            res_reg.is_paused    <= st2_reg.is_paused;
            res_reg.holding_zero <= st2_reg.holding_zero;
        end
    end

    assign res = res_reg;

endmodule

/* sv/focus_break_countdown_timer_top.sv */
// Top level of the focus and break countdown timer with its four-stage transfer pipeline.
// An accepted event moves in order through the event, status, seconds and result registers.
// Throughput: one event per cycle unless stalled; 32-bit subtracts and compares update state.
// The divisions by 1000 and 60 are reciprocal multiplications in two later stages.
// Reset clears the session state, the pipeline valid bits and restores the default durations.
`timescale 1ns / 1ps

module focus_break_countdown_timer_top
    import fbct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    output logic             evt_ready,
    input  evt_t             evt_data,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res_data,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [DUR_W-1:0] wr_data
);

    evt_t      evt_reg;
    logic      v0_reg, v0_next;
    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      v3_reg, v3_next;
    logic      adv1, adv2, adv3;
    logic      step;
    status_t   status;
    conv_ctl_t ctl;

    assign adv3      = !v3_reg || res_ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign evt_ready = !v0_reg || adv1;
    assign step      = v0_reg && adv1;

    assign ctl.ld1 = step;
    assign ctl.ld2 = v1_reg && adv2;
    assign ctl.ld3 = v2_reg && adv3;

    assign v0_next = evt_ready ? evt_valid : v0_reg;
    assign v1_next = adv1 ? v0_reg : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            evt_reg <= evt_data;
        end
    end

    fbct_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt_reg),
        .step     (step),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .status   (status)
    );

    fbct_conv u_conv (
        .clk    (clk),
        .ctl    (ctl),
        .status (status),
        .res    (res_data)
    );

    assign res_valid = v3_reg;

endmodule

/* tb/fbct_result_checker.sv */
// Checker that predicts every countdown readout of the timer and compares it with each result transfer.
`timescale 1ns / 1ps

module fbct_result_checker
    import fbct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    input  logic             evt_ready,
    input  evt_t             evt_data,
    input  logic             res_valid,
    input  logic             res_ready,
    input  res_t             res_data,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [DUR_W-1:0] wr_data,
    output int               error_count,
    output int               pending_readouts
);

    logic [DUR_W-1:0]  focus_len;
    logic [DUR_W-1:0]  break_len;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_pause;
    logic [TIME_W-1:0] t_end;
    logic [DUR_W-1:0]  left_now;
    logic              in_brk;
    logic              paused;
    logic              holding;
    res_t              predicted_readouts[$];
    res_t              want;
    int                readout_no;

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
        begin
            $display("mismatch at readout %0d: %s", readout_no, msg);
        end
        error_count++;
    endtask

    // Time left in the current session at the given stamp, clamped at zero.
    function automatic logic [DUR_W-1:0] remaining_at(input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] diff;
        elapsed = stamp - t_start;
        dur     = {{(TIME_W-DUR_W){1'b0}}, (in_brk ? break_len : focus_len)};
        diff    = dur - elapsed;
        if (elapsed >= dur)
        begin
            return '0;
        end
        return diff[DUR_W-1:0];
    endfunction

    function automatic res_t advance_timer(input evt_t ev);
        res_t        r;
        int unsigned total_s;
        case (ev.mode)
            MODE_BEGIN:
            begin
                t_start = ev.now_ms;
            end
            MODE_UPDATE:
            begin
                if (!paused)
                begin
                    if (holding)
                    begin
                        if (ev.now_ms - t_end >= HOLD_MS)
                        begin
                            in_brk   = !in_brk;
                            t_start  = ev.now_ms;
                            left_now = remaining_at(ev.now_ms);
                            holding  = 1'b0;
                        end
                    end
                    else
                    begin
                        left_now = remaining_at(ev.now_ms);
                        if (left_now == '0)
                        begin
                            t_end   = ev.now_ms;
                            holding = 1'b1;
                        end
                    end
                end
            end
            MODE_PAUSE:
            begin
                if (!paused)
                begin
                    t_pause = ev.now_ms;
                    paused  = 1'b1;
                end
                else
                begin
                    t_start = t_start + (ev.now_ms - t_pause);
                    if (holding)
                    begin
                        t_end = t_end + (ev.now_ms - t_pause);
                    end
                    paused = 1'b0;
                end
            end
            default:
            begin
                t_start = ev.now_ms;
                if (paused)
                begin
                    t_pause  = ev.now_ms;
                    left_now = remaining_at(ev.now_ms);
                end
                t_end   = '0;
                holding = 1'b0;
            end
        endcase
        total_s        = (int'(left_now) + 999) / 1000;
        r.remaining_ms = left_now;
        r.minutes      = MIN_W'(total_s / 60);
        r.seconds      = SEC_W'(total_s % 60);
        r.in_break     = in_brk;
        r.is_paused    = paused;
        r.holding_zero = holding;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_len        = FOCUS_RESET;
            break_len        = BREAK_RESET;
            t_start          = '0;
            t_pause          = '0;
            t_end            = '0;
            left_now         = '0;
            in_brk           = 1'b0;
            paused           = 1'b0;
            holding          = 1'b0;
            predicted_readouts.delete();
            error_count      = 0;
            pending_readouts = 0;
            readout_no       = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_FOCUS)
                begin
                    focus_len = (wr_data > DUR_MAX) ? DUR_MAX : wr_data;
                end
                else
                begin
                    break_len = (wr_data > DUR_MAX) ? DUR_MAX : wr_data;
                end
            end
            if (res_valid && res_ready)
            begin
                if (predicted_readouts.size() == 0)
                begin
                    report_mismatch("result transfer with no event waiting");
                end
                else
                begin
                    want = predicted_readouts.pop_front();
                    if (res_data.remaining_ms !== want.remaining_ms)
                        report_mismatch($sformatf("remaining_ms %0d, expected %0d",
                                                  res_data.remaining_ms, want.remaining_ms));
                    if (res_data.minutes !== want.minutes)
                        report_mismatch($sformatf("minutes %0d, expected %0d",
                                                  res_data.minutes, want.minutes));
                    if (res_data.seconds !== want.seconds)
                        report_mismatch($sformatf("seconds %0d, expected %0d",
                                                  res_data.seconds, want.seconds));
                    if (res_data.in_break !== want.in_break)
                        report_mismatch($sformatf("in_break %b, expected %b",
                                                  res_data.in_break, want.in_break));
                    if (res_data.is_paused !== want.is_paused)
                        report_mismatch($sformatf("is_paused %b, expected %b",
                                                  res_data.is_paused, want.is_paused));
                    if (res_data.holding_zero !== want.holding_zero)
                        report_mismatch($sformatf("holding_zero %b, expected %b",
                                                  res_data.holding_zero, want.holding_zero));
                end
                readout_no++;
            end
            if (evt_valid && evt_ready)
            begin
                predicted_readouts.push_back(advance_timer(evt_data));
            end
            pending_readouts = predicted_readouts.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top that drives timer events and duration writes and gives the final verdict.
`timescale 1ns / 1ps

module tb_top;
    import fbct_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int LATENCY     = 4;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             evt_valid;
    logic             evt_ready;
    evt_t             evt_data;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_t             res_data;
    logic             wr_en;
    logic             wr_index;
    logic [DUR_W-1:0] wr_data;
    int               error_count;
    int               pending_readouts;
    int unsigned      snd_idle = 27;
    int unsigned      rcv_idle = 64;
    logic             pause_parity = 1'b0;
    int               quiet_cycles = 0;

    focus_break_countdown_timer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    fbct_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_ready        (evt_ready),
        .evt_data         (evt_data),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_data         (res_data),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .error_count      (error_count),
        .pending_readouts (pending_readouts)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (res_valid && res_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(input logic [1:0] mode, input logic [TIME_W-1:0] stamp);
        evt_valid = 1'b1;
        evt_data  = {mode, stamp};
        do @(posedge clk); while (!evt_ready);
        if (mode == MODE_PAUSE)
        begin
            pause_parity = !pause_parity;
        end
        @(negedge clk);
        if ($urandom_range(99) < snd_idle)
        begin
            evt_valid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    task automatic settle();
        evt_valid = 1'b0;
        do @(negedge clk); while (pending_readouts != 0);
    endtask

    task automatic write_register(input logic idx, input logic [DUR_W-1:0] value);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = value;
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    // Mostly plausible session sequences on a moving clock, with some scattered noise.
    task automatic run_sessions(input int unsigned step_hi, input int unsigned count);
        int unsigned       done;
        int unsigned       pick;
        logic [TIME_W-1:0] wall;
        logic [TIME_W-1:0] stamp;
        logic [1:0]        mode;
        logic              was_paused;
        done = 0;
        wall = $urandom;
        while (done < count)
        begin
            pick       = $urandom_range(99);
            was_paused = pause_parity;
            if (was_paused)
            begin
                wall = wall + $urandom_range(0, step_hi);
                if (pick < 60)
                    mode = MODE_PAUSE;
                else if (pick < 75)
                    mode = MODE_RESET;
                else if (pick < 85)
                    mode = MODE_BEGIN;
                else
                    mode = MODE_UPDATE;
                stamp = wall;
            end
            else if (pick < 12)
            begin
                mode  = 2'($urandom_range(3));
                stamp = $urandom;
            end
            else
            begin
                if (pick < 30)
                begin
                    mode = MODE_UPDATE;
                    wall = wall + $urandom_range(0, 1500);
                end
                else if (pick < 70)
                begin
                    mode = MODE_UPDATE;
                    wall = wall + $urandom_range(0, step_hi);
                end
                else if (pick < 80)
                begin
                    mode = MODE_PAUSE;
                    wall = wall + $urandom_range(0, step_hi);
                end
                else if (pick < 87)
                    mode = MODE_BEGIN;
                else if (pick < 93)
                    mode = MODE_RESET;
                else
                begin
                    mode = MODE_UPDATE;
                    wall = wall + $urandom_range(step_hi, 8 * step_hi);
                end
                stamp = wall;
            end
            send_event(mode, stamp);
            if (!(mode == MODE_UPDATE && was_paused))
            begin
                done++;
            end
            if ($urandom_range(199) == 0)
            begin
                settle();
            end
        end
    endtask

    initial
    begin
        logic [DUR_W-1:0] focus_set;
        logic [DUR_W-1:0] break_set;
        int unsigned      step_hi;
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt_data  = '0;
        wr_en     = 1'b0;
        wr_index  = REG_FOCUS;
        wr_data   = '0;
        focus_set = FOCUS_RESET;
        break_set = BREAK_RESET;
        step_hi   = 80000;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk through a focus session, its hold, a break and back, with wraps.
        send_event(MODE_BEGIN,  32'h0000_0000);
        send_event(MODE_UPDATE, 32'h0000_0000);
        send_event(MODE_UPDATE, 32'hFFFF_FFFF);
        send_event(MODE_UPDATE, 32'd999);
        send_event(MODE_BEGIN,  32'hFFFF_FF00);
        send_event(MODE_UPDATE, 32'h0000_0100);
        send_event(MODE_PAUSE,  32'h0000_0200);
        send_event(MODE_UPDATE, 32'h1234_5678);
        send_event(MODE_RESET,  32'h0000_0300);
        send_event(MODE_PAUSE,  32'd5768);
        send_event(MODE_UPDATE, 32'd305767);
        send_event(MODE_UPDATE, 32'd305768);
        send_event(MODE_UPDATE, 32'd306767);
        send_event(MODE_PAUSE,  32'd306767);
        send_event(MODE_PAUSE,  32'd313767);
        send_event(MODE_UPDATE, 32'd313767);
        send_event(MODE_UPDATE, 32'd313768);
        send_event(MODE_UPDATE, 32'd1753768);
        send_event(MODE_UPDATE, 32'd1753769);
        send_event(MODE_UPDATE, 32'd1812767);
        send_event(MODE_UPDATE, 32'd1813768);
        send_event(MODE_RESET,  32'd1813800);
        send_event(MODE_UPDATE, 32'd1813810);
        send_event(MODE_PAUSE,  32'hFFFF_FFFF);
        send_event(MODE_PAUSE,  32'h0000_0000);

        for (int ph = 0; ph < 6; ph++)
        begin
            snd_idle = (ph < 2) ? 27 : (ph < 4) ? 64 : 0;
            rcv_idle = (ph < 2) ? 64 : (ph < 4) ? 27 : 0;
            settle();
            case (ph)
                1:
                begin
                    focus_set = 23'd3000;
                    break_set = 23'd1500;
                    step_hi   = 800;
                end
                2:
                begin
                    focus_set = 23'd0;
                    break_set = 23'd2000;
                    step_hi   = 700;
                end
                3:
                begin
                    focus_set = 23'd8388607;
                    break_set = 23'd0;
                    step_hi   = 400000;
                end
                4:
                begin
                    focus_set = DUR_MAX;
                    break_set = 23'd6000000;
                    step_hi   = 400000;
                end
                5:
                begin
                    focus_set = 23'd1;
                    break_set = 23'd999;
                    step_hi   = 600;
                end
                default:
                begin
                    step_hi = 80000;
                end
            endcase
            if (ph != 0)
            begin
                write_register(REG_FOCUS, focus_set);
                write_register(REG_BREAK, break_set);
            end
            run_sessions(step_hi, 267);
        end

        settle();
        repeat (2 * LATENCY) @(negedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* focus_break_countdown_timer_top.f */
sv/fbct_pkg.sv
sv/fbct_core.sv
sv/fbct_conv.sv
sv/focus_break_countdown_timer_top.sv
tb/fbct_result_checker.sv
tb/tb_top.sv
